// File: hdl/dorq_pkg.sv
// shared types and constants of the deadline ordered request queue
package dorq_pkg;

  localparam int QueueDepth = 16;
  localparam int IdxW       = $clog2(QueueDepth);
  localparam int CntW       = $clog2(QueueDepth + 1);
  localparam int PosW       = 4;
  localparam int RmIdxW     = 4;

  typedef enum logic {
    OpInsert = 1'b0,
    OpRemove = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    StDone     = 2'd0,
    StFull     = 2'd1,
    StEmptyIdx = 2'd2
  } status_e;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [15:0] qty;
    logic [15:0] id;
  } entry_t;

  // broadcast to every cell of the row
  typedef struct packed {
    logic              ins;
    logic              rm;
    logic [CntW-1:0]   count;
    logic [RmIdxW-1:0] rm_idx;
    entry_t            new_entry;
  } cell_ctrl_t;

endpackage

// File: hdl/dorq_cell.sv
// one slot of the sorted queue row, shifting towards the tail or the head
module dorq_cell (
  input  logic                      clk_i,
  input  logic [dorq_pkg::IdxW-1:0] cell_idx_i,
  input  dorq_pkg::cell_ctrl_t      ctrl_i,
  input  dorq_pkg::entry_t          left_entry_i,
  input  logic                      left_gt_i,
  input  dorq_pkg::entry_t          right_entry_i,
  output dorq_pkg::entry_t          entry_o,
  output logic                      gt_o,
  output logic                      take_new_o
);

  dorq_pkg::entry_t entry_q, entry_d;
  logic             valid;
  logic             at_tail;
  logic             has_next;
  logic             from_right;

  always_comb begin
    valid    = dorq_pkg::CntW'(cell_idx_i) < ctrl_i.count;
    at_tail  = dorq_pkg::CntW'(cell_idx_i) == ctrl_i.count;
    has_next = (dorq_pkg::CntW'(cell_idx_i) + dorq_pkg::CntW'(1)) < ctrl_i.count;
    // month stays below the date scale, so year then month orders like the key
    gt_o = valid && ({entry_q.year, entry_q.month} >
                     {ctrl_i.new_entry.year, ctrl_i.new_entry.month});
    take_new_o = ctrl_i.ins && !left_gt_i && (gt_o || at_tail);
    from_right = ctrl_i.rm && has_next &&
                 (32'(cell_idx_i) >= 32'(ctrl_i.rm_idx));
  end

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins && left_gt_i) begin
      entry_d = left_entry_i;
    end else if (take_new_o) begin
      entry_d = ctrl_i.new_entry;
    end else if (from_right) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// File: hdl/deadline_ordered_request_queue.sv
// top level of the deadline ordered request queue: cell row, count and result register
//
// channel   dir  tdata (low bit up)                                  tuser
// s_axis    in   item_id, quantity, due_month, due_year, remove_index operation
// m_axis    out  position, occupancy, removed_id, removed_quantity,   status
//                removed_month, removed_year
//
// one transaction per cycle while no result stalls: all cells compare the new key in
// parallel and the row shifts in the cycle of acceptance; the result follows next cycle
// reset clears the entry count and the result valid flag; cell contents are not reset
// a stalled result holds; a new transaction is taken in the cycle the result leaves
module deadline_ordered_request_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [15:0] item_id, [31:16] quantity, [35:32] due_month, [47:36] due_year,
  // [51:48] remove_index, [55:52] zero
  input  logic [55:0] s_axis_tdata_i,
  // [0] operation
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [3:0] position, [8:4] occupancy, [24:9] removed_id, [40:25] removed_quantity,
  // [44:41] removed_month, [56:45] removed_year, [63:57] zero
  output logic [63:0] m_axis_tdata_o,
  // [1:0] status
  output logic [1:0]  m_axis_tuser_o
);

  localparam int Depth = dorq_pkg::QueueDepth;

  logic [dorq_pkg::CntW-1:0]   count_q, count_d;
  logic                        out_valid_q;
  dorq_pkg::status_e           status_q, status_d;
  logic [dorq_pkg::PosW-1:0]   position_q, position_d;
  logic [dorq_pkg::CntW-1:0]   occ_q;
  dorq_pkg::entry_t            removed_q, removed_d;

  logic                        in_fire;
  logic                        is_ins;
  logic                        full;
  logic                        idx_hit;
  dorq_pkg::op_e               op;
  logic [dorq_pkg::RmIdxW-1:0] rm_idx;
  dorq_pkg::entry_t            new_entry;
  dorq_pkg::cell_ctrl_t        ctrl;
  logic [dorq_pkg::IdxW-1:0]   ins_pos;

  dorq_pkg::entry_t            cell_entry [Depth];
  logic [Depth-1:0]            cell_gt;
  logic [Depth-1:0]            cell_take;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    op              = dorq_pkg::op_e'(s_axis_tuser_i);
    new_entry.id    = s_axis_tdata_i[15:0];
    new_entry.qty   = s_axis_tdata_i[31:16];
    new_entry.month = s_axis_tdata_i[35:32];
    new_entry.year  = s_axis_tdata_i[47:36];
    rm_idx          = s_axis_tdata_i[51:48];
    is_ins          = op == dorq_pkg::OpInsert;
    full            = count_q >= dorq_pkg::CntW'(Depth);
    idx_hit         = 32'(rm_idx) < 32'(count_q);
    ctrl.ins        = in_fire && is_ins && !full;
    ctrl.rm         = in_fire && !is_ins && idx_hit;
    ctrl.count      = count_q;
    ctrl.rm_idx     = rm_idx;
    ctrl.new_entry  = new_entry;
  end

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    dorq_pkg::entry_t left_e, right_e;
    logic             left_gt;
    if (i == 0) begin : g_head
      assign left_e  = new_entry;
      assign left_gt = 1'b0;
    end else begin : g_mid
      assign left_e  = cell_entry[i-1];
      assign left_gt = cell_gt[i-1];
    end
    if (i == Depth - 1) begin : g_tail
      assign right_e = cell_entry[i];
    end else begin : g_body
      assign right_e = cell_entry[i+1];
    end
    dorq_cell u_cell (
      .clk_i         (clk_i),
      .cell_idx_i    (dorq_pkg::IdxW'(i)),
      .ctrl_i        (ctrl),
      .left_entry_i  (left_e),
      .left_gt_i     (left_gt),
      .right_entry_i (right_e),
      .entry_o       (cell_entry[i]),
      .gt_o          (cell_gt[i]),
      .take_new_o    (cell_take[i])
    );
  end

  // exactly one cell takes the new entry on an insert that fits
  always_comb begin
    ins_pos   = '0;
    removed_d = '0;
    for (int i = 0; i < Depth; i++) begin
      if (cell_take[i]) begin
        ins_pos = ins_pos | dorq_pkg::IdxW'(i);
      end
      if (32'(rm_idx) == i) begin
        removed_d = removed_d | cell_entry[i];
      end
    end
    if (!ctrl.rm) begin
      removed_d = '0;
    end
  end

  always_comb begin
    count_d    = count_q;
    status_d   = dorq_pkg::StDone;
    position_d = '0;
    if (is_ins) begin
      if (full) begin
        status_d = dorq_pkg::StFull;
      end else begin
        count_d    = count_q + dorq_pkg::CntW'(1);
        position_d = dorq_pkg::PosW'(ins_pos);
      end
    end else begin
      position_d = dorq_pkg::PosW'(rm_idx);
      if (idx_hit) begin
        count_d = count_q - dorq_pkg::CntW'(1);
      end else begin
        status_d = dorq_pkg::StEmptyIdx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      status_q   <= status_d;
      position_q <= position_d;
      occ_q      <= count_d;
      removed_q  <= removed_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = status_q;
  assign m_axis_tdata_o  = {7'd0, removed_q.year, removed_q.month, removed_q.qty,
                            removed_q.id, 5'(occ_q), position_q};

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= dorq_pkg::CntW'(Depth))
    else $error("entry count beyond queue depth");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> $stable(count_q))
    else $error("entry count moved without a transaction");

  a_occ_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> occ_q == count_q)
    else $error("reported occupancy differs from entry count");

  a_one_taker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ins |-> $onehot(cell_take))
    else $error("insert not taken by exactly one cell");

  a_no_taker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctrl.ins |-> cell_take == '0)
    else $error("cell took an entry without an insert");
`endif

endmodule
